// ----- rtl/i2c_master_register_access_defines.svh -----
// Assertion macros used by the top level of the I2C register access master.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

`ifndef SYNTH

// The condition must hold at every clock edge outside reset.
`define I2CM_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("i2cm assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define I2CM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// When the antecedent holds, the consequent must hold in the following cycle.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT_HOLDS(label, clk, rst_n, cond)
`define I2CM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/i2cm_pkg.sv -----
// Types, constants and sequence tables of the I2C register access master.
package i2cm_pkg;

    // Command field encodings on the input channel.
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_PHASE_TICKS    = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'h68;
    localparam logic [15:0] PHASE_TICKS_RESET    = 16'd72;

    localparam int unsigned STEP_W = 4;
    localparam int unsigned SUB_W  = 5;

    // Number of segments in each transaction.
    localparam logic [STEP_W-1:0] WR_SEGS = 4'd8;
    localparam logic [STEP_W-1:0] RD_SEGS = 4'd11;

    // Sub-step of the eighth bit's falling SCL edge inside a byte segment.
    localparam logic [SUB_W-1:0] LAST_BIT_SUB = 5'd25;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_READ
    } cmd_t;

    typedef enum logic [2:0] {
        SEG_START,
        SEG_WBYTE,
        SEG_ACK,
        SEG_STOP,
        SEG_RBYTE,
        SEG_NACK
    } seg_t;

    typedef enum logic [1:0] {
        SRC_ADDR_W,
        SRC_REG,
        SRC_DATA,
        SRC_ADDR_R
    } src_t;

    typedef enum logic [1:0] {
        SLOT_SETUP,
        SLOT_HIGH,
        SLOT_LOW
    } slot_t;

    // One classified tick as it sits in the front queue.
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda;
        logic       scl;
    } item_t;

    // One result tick as it sits in the output queue.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       nack_seen;
        logic       clock_held;
    } result_t;

    // Sequencer status seen by the top level.
    typedef struct packed {
        logic busy;
        logic phase_wait;
    } seq_status_t;

    function automatic logic [STEP_W-1:0] seg_count(input logic is_read);
        return is_read ? RD_SEGS : WR_SEGS;
    endfunction

    function automatic seg_t seg_kind(input logic is_read, input logic [STEP_W-1:0] step);
        seg_t k;
        k = SEG_STOP;
        if (is_read) begin
            case (step)
                4'd1:    k = SEG_START;
                4'd2:    k = SEG_WBYTE;
                4'd3:    k = SEG_ACK;
                4'd4:    k = SEG_WBYTE;
                4'd5:    k = SEG_ACK;
                4'd6:    k = SEG_START;
                4'd7:    k = SEG_WBYTE;
                4'd8:    k = SEG_ACK;
                4'd9:    k = SEG_RBYTE;
                4'd10:   k = SEG_NACK;
                default: k = SEG_STOP;
            endcase
        end else begin
            case (step)
                4'd1:    k = SEG_START;
                4'd2:    k = SEG_WBYTE;
                4'd3:    k = SEG_ACK;
                4'd4:    k = SEG_WBYTE;
                4'd5:    k = SEG_ACK;
                4'd6:    k = SEG_WBYTE;
                4'd7:    k = SEG_ACK;
                default: k = SEG_STOP;
            endcase
        end
        return k;
    endfunction

    function automatic src_t seg_src(input logic is_read, input logic [STEP_W-1:0] step);
        src_t s;
        s = SRC_ADDR_W;
        case (step)
            4'd4:    s = SRC_REG;
            4'd6:    s = is_read ? SRC_ADDR_W : SRC_DATA;
            4'd7:    s = is_read ? SRC_ADDR_R : SRC_ADDR_W;
            default: s = SRC_ADDR_W;
        endcase
        return s;
    endfunction

    function automatic logic [SUB_W-1:0] seg_len(input seg_t kind);
        logic [SUB_W-1:0] n;
        case (kind)
            SEG_START: n = 5'd6;
            SEG_WBYTE: n = 5'd26;
            SEG_ACK:   n = 5'd4;
            SEG_STOP:  n = 5'd3;
            SEG_RBYTE: n = 5'd26;
            SEG_NACK:  n = 5'd4;
            default:   n = 5'd3;
        endcase
        return n;
    endfunction

    // Position of a byte segment sub-step within its three-step bit slot.
    function automatic slot_t bit_slot(input logic [SUB_W-1:0] m);
        slot_t s;
        case (m)
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23: s = SLOT_SETUP;
            5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: s = SLOT_HIGH;
            5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd25: s = SLOT_LOW;
            default: s = SLOT_SETUP;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/i2c_master_register_access.sv -----
// Top level of the I2C master for single-byte register reads and writes.
//
// Each input transfer is one tick of the bus sequencer: an optional command
// (write or read register) with its register address and data, plus the sampled
// SDA and SCL levels. Every accepted tick yields exactly one result transfer
// carrying the SCL and SDA drive levels, busy, a done pulse, the read byte and
// the two status flags. Commands that arrive while a transaction runs are ignored.
// Both channels use valid and ready; a two-entry queue sits on each side of the
// sequencer, so the input side keeps taking ticks while a result waits.
// Throughput is one tick per cycle while the receiver takes results; the sequencer
// updates its whole state for each tick. An input tick is first stored in the input
// queue, then its result is registered into the output queue.
// When the receiver stalls, the output queue fills, the sequencer stops, then
// the input queue fills and in_ready drops; no tick is lost or repeated.
// Reset leaves the bus released (both lines high), the sequencer idle, the
// device address at 0x68 and 72 ticks per bus phase. Configuration writes take
// effect at once and are meant to be made only while the block is idle.
`include "i2c_master_register_access_defines.svh"

module i2c_master_register_access
    import i2cm_pkg::*;
#(
    parameter int unsigned PHASE_COUNTER_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  reg_address,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    input  logic        scl_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_data,
    output logic        nack_seen,
    output logic        clock_held
);

    logic [6:0]  device_address_reg;
    logic [15:0] phase_ticks_reg;
    logic        queue_valid;
    item_t       queue_head;
    logic        out_space;
    logic        seq_fire;
    result_t     seq_result;
    result_t     out_head;
    seq_status_t seq_status;

    // Configuration registers, written without handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            phase_ticks_reg    <= PHASE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                REG_PHASE_TICKS:    phase_ticks_reg    <= cfg_data;
                default:            phase_ticks_reg    <= phase_ticks_reg;
            endcase
        end
    end

    i2cm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .reg_address (reg_address),
        .write_data  (write_data),
        .sda_in      (sda_in),
        .scl_in      (scl_in),
        .pop         (seq_fire),
        .head_valid  (queue_valid),
        .head        (queue_head)
    );

    // The sequencer steps whenever a tick is queued and its result has a slot.
    assign seq_fire = queue_valid && out_space;

    i2cm_seq #(
        .PHASE_COUNTER_BITS (PHASE_COUNTER_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (device_address_reg),
        .phase_ticks    (phase_ticks_reg),
        .fire           (seq_fire),
        .item           (queue_head),
        .result         (seq_result),
        .status         (seq_status)
    );

    i2cm_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (seq_fire),
        .push_data (seq_result),
        .space     (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (out_head)
    );

    assign scl_out    = out_head.scl_out;
    assign sda_out    = out_head.sda_out;
    assign busy_res   = out_head.busy;
    assign done_res   = out_head.done;
    assign read_data  = out_head.read_data;
    assign nack_seen  = out_head.nack_seen;
    assign clock_held = out_head.clock_held;

    // An accepted command on an idle sequencer starts a transaction.
    `I2CM_ASSERT_NEXT(a_cmd_starts, clk, rst_n, seq_fire && !seq_status.busy && queue_head.cmd != CMD_NONE, seq_status.busy)
    // Done only ends a running transaction and leaves the sequencer idle.
    `I2CM_ASSERT_IMPL(a_done_ends_busy, clk, rst_n, seq_fire && seq_result.done, seq_status.busy && !seq_result.busy)
    // A tick spent waiting out a phase never finishes the transaction.
    `I2CM_ASSERT_IMPL(a_wait_keeps_busy, clk, rst_n, seq_fire && seq_status.phase_wait, seq_result.busy && !seq_result.done)
    // With no transaction running the bus is released.
    `I2CM_ASSERT_IMPL(a_idle_bus_high, clk, rst_n, out_valid && !busy_res, scl_out && sda_out)

endmodule

// ----- rtl/i2cm_front.sv -----
// Front end: accepts input ticks, classifies the command and queues them.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    input  logic       scl_in,
    input  logic       pop,
    output logic       head_valid,
    output item_t      head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    item_t      incoming;

    // Unused command codes are treated as no command.
    always_comb
    begin
        case (func)
            FUNC_WRITE: incoming.cmd = CMD_WRITE;
            FUNC_READ:  incoming.cmd = CMD_READ;
            default:    incoming.cmd = CMD_NONE;
        endcase
        incoming.reg_address = reg_address;
        incoming.write_data  = write_data;
        incoming.sda         = sda_in;
        incoming.scl         = scl_in;
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- rtl/i2cm_seq.sv -----
// Back end: bus sequencer that advances one tick per dequeued item.
module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int unsigned PHASE_COUNTER_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  device_address,
    input  logic [15:0] phase_ticks,
    input  logic        fire,
    input  item_t       item,
    output result_t     result,
    output seq_status_t status
);

    localparam int unsigned PCB   = PHASE_COUNTER_BITS;
    localparam int unsigned CMP_W = (PCB > 16) ? PCB : 16;

    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUB_W-1:0]  sub_reg, sub_next, sub_inc;
    logic [PCB-1:0]    pc_reg, pc_next, reload_val;
    logic [7:0]        shift_reg, shift_next;
    logic              is_read_reg, is_read_next;
    logic [7:0]        held_register_reg, held_register_next;
    logic [7:0]        held_data_reg, held_data_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;
    logic              nack_reg, nack_next;
    logic              clk_held_reg, clk_held_next;
    logic              done;
    logic              do_act;
    seg_t              act_kind;
    slot_t             act_slot;
    logic [15:0]       ticks_m1;
    logic [CMP_W-1:0]  ticks_ext, pc_max_ext;

    // Phase reload: ticks minus one, zero acts as one, saturated to the counter.
    assign ticks_m1   = (phase_ticks == 16'd0) ? 16'd0 : phase_ticks - 16'd1;
    assign ticks_ext  = CMP_W'(ticks_m1);
    assign pc_max_ext = CMP_W'({PCB{1'b1}});
    assign reload_val = (ticks_ext > pc_max_ext) ? pc_max_ext[PCB-1:0] : ticks_ext[PCB-1:0];

    always_comb
    begin
        step_next          = step_reg;
        sub_next           = sub_reg;
        pc_next            = pc_reg;
        shift_next         = shift_reg;
        is_read_next       = is_read_reg;
        held_register_next = held_register_reg;
        held_data_next     = held_data_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        nack_next          = nack_reg;
        clk_held_next      = clk_held_reg;
        done               = 1'b0;
        do_act             = 1'b0;
        sub_inc            = sub_reg + 5'd1;

        if (fire)
        begin
            if (step_reg == '0)
            begin
                if (item.cmd == CMD_WRITE || item.cmd == CMD_READ)
                begin
                    is_read_next       = (item.cmd == CMD_READ);
                    held_register_next = item.reg_address;
                    held_data_next     = (item.cmd == CMD_READ) ? 8'd0 : item.write_data;
                    nack_next          = 1'b0;
                    clk_held_next      = 1'b0;
                    step_next          = 4'd1;
                    sub_next           = '0;
                    do_act             = 1'b1;
                end
            end
            else if (pc_reg != '0)
            begin
                pc_next = pc_reg - 1'b1;
            end
            else
            begin
                if (sub_inc >= seg_len(seg_kind(is_read_reg, step_reg)))
                begin
                    sub_next  = '0;
                    step_next = step_reg + 4'd1;
                end
                else
                begin
                    sub_next = sub_inc;
                end
                if (step_next > seg_count(is_read_reg))
                begin
                    step_next = '0;
                    sub_next  = '0;
                    done      = 1'b1;
                end
                else
                begin
                    do_act = 1'b1;
                end
            end
        end

        act_kind = seg_kind(is_read_next, step_next);
        act_slot = bit_slot(sub_next);

        if (do_act)
        begin
            pc_next = reload_val;
            case (act_kind)
                SEG_WBYTE, SEG_RBYTE:
                begin
                    if (sub_next == 5'd0)
                    begin
                        scl_next = 1'b0;
                        if (act_kind == SEG_WBYTE)
                        begin
                            case (seg_src(is_read_next, step_next))
                                SRC_ADDR_W: shift_next = {device_address, 1'b0};
                                SRC_REG:    shift_next = held_register_next;
                                SRC_DATA:   shift_next = held_data_next;
                                default:    shift_next = {device_address, 1'b1};
                            endcase
                        end
                        else
                        begin
                            shift_next = 8'd0;
                        end
                    end
                    else if (sub_next == 5'd1)
                    begin
                        sda_next = (act_kind == SEG_RBYTE);
                    end
                    else if (act_kind == SEG_WBYTE)
                    begin
                        case (act_slot)
                            SLOT_SETUP: sda_next = shift_reg[7];
                            SLOT_HIGH:  scl_next = 1'b1;
                            default:
                            begin
                                scl_next   = 1'b0;
                                shift_next = {shift_reg[6:0], 1'b0};
                            end
                        endcase
                    end
                    else
                    begin
                        case (act_slot)
                            SLOT_SETUP: scl_next = 1'b1;
                            SLOT_HIGH:  shift_next = {shift_reg[6:0], item.sda};
                            default:
                            begin
                                scl_next = 1'b0;
                                if (sub_next == LAST_BIT_SUB)
                                begin
                                    held_data_next = shift_reg;
                                end
                            end
                        endcase
                    end
                end
                SEG_START:
                begin
                    case (sub_next)
                        5'd0: scl_next = 1'b0;
                        5'd1: sda_next = 1'b1;
                        5'd2: scl_next = 1'b1;
                        5'd3:
                        begin
                            if (!item.scl)
                            begin
                                clk_held_next = 1'b1;
                            end
                        end
                        5'd4:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                SEG_ACK, SEG_NACK:
                begin
                    case (sub_next)
                        5'd0: scl_next = 1'b0;
                        5'd1: sda_next = 1'b1;
                        5'd2: scl_next = 1'b1;
                        default:
                        begin
                            if (act_kind == SEG_ACK && item.sda)
                            begin
                                nack_next = 1'b1;
                            end
                            scl_next = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    case (sub_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
            endcase
        end
    end

    always_comb
    begin
        result.scl_out    = scl_next;
        result.sda_out    = sda_next;
        result.busy       = (step_next != '0);
        result.done       = done;
        result.read_data  = is_read_next ? held_data_next : 8'd0;
        result.nack_seen  = nack_next;
        result.clock_held = clk_held_next;
    end

    assign status.busy       = (step_reg != '0);
    assign status.phase_wait = (step_reg != '0) && (pc_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= '0;
            sub_reg           <= '0;
            pc_reg            <= '0;
            shift_reg         <= 8'd0;
            is_read_reg       <= 1'b0;
            held_register_reg <= 8'd0;
            held_data_reg     <= 8'd0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
            nack_reg          <= 1'b0;
            clk_held_reg      <= 1'b0;
        end
        else
        begin
            step_reg          <= step_next;
            sub_reg           <= sub_next;
            pc_reg            <= pc_next;
            shift_reg         <= shift_next;
            is_read_reg       <= is_read_next;
            held_register_reg <= held_register_next;
            held_data_reg     <= held_data_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
            nack_reg          <= nack_next;
            clk_held_reg      <= clk_held_next;
        end
    end

endmodule

// ----- rtl/i2cm_out.sv -----
// Output queue: holds finished results until the receiver takes them.
module i2cm_out
    import i2cm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t head
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign space     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
